>>> rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared sizes, command word and helpers for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int POOL_BLOCKS   = 256;
  localparam int MAP_WORD_BITS = 64;
  localparam int NUM_WORDS     = (POOL_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

  localparam int IDX_W      = 8;   // block_index / block_number width
  localparam int CNT_OUT_W  = 9;   // free_blocks width
  localparam int BIT_W      = $clog2(MAP_WORD_BITS);
  localparam int WSEL_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int COUNT_W    = $clog2(POOL_BLOCKS + 1);
  localparam int CNT_SAT    = (1 << CNT_OUT_W) - 1;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Decoded request word between front and back
  typedef struct packed {
    logic              is_alloc;
    logic              in_range;
    logic [WSEL_W-1:0] word_sel;
    logic [BIT_W-1:0]  bit_sel;
    logic [IDX_W-1:0]  index;
  } cmd_t;

  typedef logic [MAP_WORD_BITS-1:0] map_word_t;

  // Position of the lowest set bit; zero for an all-zero word
  function automatic logic [BIT_W-1:0] lowest_set(input map_word_t w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  // Reset contents of one map word: ones for blocks inside the pool
  function automatic map_word_t reset_word(input int w);
    map_word_t r;
    r = '0;
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      if (w * MAP_WORD_BITS + b < POOL_BLOCKS) r[b] = 1'b1;
    end
    return r;
  endfunction

endpackage

>>> rtl/bba_front.sv
// ----------------------------------------------------------------------------
// bba_front
// Input stage: takes request words and decodes them into command words.
// ----------------------------------------------------------------------------
module bba_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic                      kind_i,
  input  logic [bba_pkg::IDX_W-1:0] block_index_i,
  output logic                      cmd_vld_o,
  output bba_pkg::cmd_t             cmd_o,
  input  logic                      cmd_rdy_i
);

  logic          vld_q, vld_d;
  bba_pkg::cmd_t cmd_q, cmd_d;
  logic          accept;
  logic          hand_off;

  assign hand_off = vld_q & cmd_rdy_i;
  assign full     = vld_q & ~cmd_rdy_i;
  assign accept   = push & ~full;

  always_comb begin
    cmd_d          = cmd_q;
    cmd_d.is_alloc = (kind_i == bba_pkg::KIND_ALLOC);
    cmd_d.in_range = (32'(block_index_i) < bba_pkg::POOL_BLOCKS);
    cmd_d.word_sel = bba_pkg::WSEL_W'(block_index_i >> bba_pkg::BIT_W);
    cmd_d.bit_sel  = bba_pkg::BIT_W'(block_index_i);
    cmd_d.index    = block_index_i;
  end

  always_comb begin
    vld_d = vld_q;
    if (accept)        vld_d = 1'b1;
    else if (hand_off) vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_vld_o = vld_q;
  assign cmd_o     = cmd_q;

endmodule

>>> rtl/bba_cmd_fifo.sv
// ----------------------------------------------------------------------------
// bba_cmd_fifo
// Two-entry command queue decoupling decode from map update.
// ----------------------------------------------------------------------------
module bba_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_vld_i,
  output logic          wr_rdy_o,
  input  bba_pkg::cmd_t wr_cmd_i,
  output logic          rd_vld_o,
  input  logic          rd_en_i,
  output bba_pkg::cmd_t rd_cmd_o
);

  bba_pkg::cmd_t mem_q [2];
  logic          wp_q, wp_d, rp_q, rp_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_wr, do_rd;

  assign wr_rdy_o = (cnt_q != 2'd2);
  assign rd_vld_o = (cnt_q != 2'd0);
  assign do_wr    = wr_vld_i & wr_rdy_o;
  assign do_rd    = rd_en_i & rd_vld_o;
  assign rd_cmd_o = mem_q[rp_q];

  always_comb begin
    wp_d  = do_wr ? ~wp_q : wp_q;
    rp_d  = do_rd ? ~rp_q : rp_q;
    cnt_d = cnt_q;
    if (do_wr && !do_rd)      cnt_d = cnt_q + 2'd1;
    else if (do_rd && !do_wr) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_cmd_i;
    end
  end

endmodule

>>> rtl/bba_back.sv
// ----------------------------------------------------------------------------
// bba_back
// Map engine: holds the free map, scans it a word per cycle, registers results.
// ----------------------------------------------------------------------------
module bba_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_vld_i,
  input  bba_pkg::cmd_t                 cmd_i,
  output logic                          cmd_rd_o,
  output logic                          empty,
  input  logic                          pop,
  output logic                          granted_o,
  output logic [bba_pkg::IDX_W-1:0]     block_number_o,
  output logic [bba_pkg::CNT_OUT_W-1:0] free_blocks_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  localparam int NUM_W = bba_pkg::WSEL_W + bba_pkg::BIT_W;

  logic                            st_q, st_d;
  logic [bba_pkg::WSEL_W-1:0]      scan_w_q, scan_w_d;
  bba_pkg::map_word_t              map_q [bba_pkg::NUM_WORDS];
  bba_pkg::map_word_t              map_d [bba_pkg::NUM_WORDS];
  logic [bba_pkg::COUNT_W-1:0]     count_q, count_d;

  logic                            out_vld_q, out_vld_d;
  logic                            res_we;
  logic                            res_granted;
  logic [bba_pkg::IDX_W-1:0]       res_number;
  logic                            granted_q;
  logic [bba_pkg::IDX_W-1:0]       number_q;
  logic [bba_pkg::CNT_OUT_W-1:0]   free_q;

  logic                            out_free;
  bba_pkg::map_word_t              scan_word;
  logic [bba_pkg::BIT_W-1:0]       scan_bit;
  logic                            free_bit;
  logic                            last_word;

  assign out_free  = ~out_vld_q | pop;
  assign scan_word = map_q[scan_w_q];
  assign scan_bit  = bba_pkg::lowest_set(scan_word);
  assign free_bit  = map_q[cmd_i.word_sel][cmd_i.bit_sel];
  assign last_word = (scan_w_q == bba_pkg::WSEL_W'(bba_pkg::NUM_WORDS - 1));

  always_comb begin
    st_d        = st_q;
    scan_w_d    = scan_w_q;
    map_d       = map_q;
    count_d     = count_q;
    cmd_rd_o    = 1'b0;
    res_we      = 1'b0;
    res_granted = 1'b0;
    res_number  = '0;
    case (st_q)
      ST_IDLE: begin
        if (cmd_vld_i && out_free) begin
          cmd_rd_o = 1'b1;
          if (cmd_i.is_alloc) begin
            st_d     = ST_SCAN;
            scan_w_d = '0;
          end else begin
            // free: setting an already free bit is a no-op
            res_we      = 1'b1;
            res_granted = cmd_i.in_range;
            res_number  = cmd_i.index;
            if (cmd_i.in_range && !free_bit) begin
              map_d[cmd_i.word_sel][cmd_i.bit_sel] = 1'b1;
              count_d = count_q + 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        if (scan_word != '0) begin
          map_d[scan_w_q][scan_bit] = 1'b0;
          count_d     = count_q - 1'b1;
          res_we      = 1'b1;
          res_granted = 1'b1;
          res_number  = bba_pkg::IDX_W'(NUM_W'({scan_w_q, scan_bit}));
          st_d        = ST_IDLE;
        end else if (last_word) begin
          // pool exhausted
          res_we = 1'b1;
          st_d   = ST_IDLE;
        end else begin
          scan_w_d = scan_w_q + 1'b1;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q & ~pop;
    if (res_we) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      scan_w_q  <= '0;
      count_q   <= bba_pkg::COUNT_W'(bba_pkg::POOL_BLOCKS);
      out_vld_q <= 1'b0;
      for (int w = 0; w < bba_pkg::NUM_WORDS; w++) begin
        map_q[w] <= bba_pkg::reset_word(w);
      end
    end else begin
      st_q      <= st_d;
      scan_w_q  <= scan_w_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
      map_q     <= map_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      granted_q <= res_granted;
      number_q  <= res_number;
      if (32'(count_d) > bba_pkg::CNT_SAT) free_q <= bba_pkg::CNT_OUT_W'(bba_pkg::CNT_SAT);
      else                                 free_q <= bba_pkg::CNT_OUT_W'(count_d);
    end
  end

  assign empty          = ~out_vld_q;
  assign granted_o      = granted_q;
  assign block_number_o = number_q;
  assign free_blocks_o  = free_q;

endmodule

>>> rtl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a free bitmap (one bit per block, 1 = free).
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake        Word
//  request   in         push / full      kind_i, block_index_i
//  result    out        empty / pop      granted_o, block_number_o, free_blocks_o
//
// Flow: a request is registered and decoded in the front stage, queued, then
// executed by the map engine. A free is done straight from idle; an allocate
// is dispatched, then inspects map words lowest first until one has a free
// bit, as the engine reads a single map word per cycle.
// Reset: all blocks inside the pool are free, count = POOL_BLOCKS, queues empty.
// Stalls: the engine only starts a request once the result register is free;
// the front stage and command queue keep accepting up to three requests ahead.
//
module bitmap_block_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          kind_i,
  input  logic [bba_pkg::IDX_W-1:0]     block_index_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          granted_o,
  output logic [bba_pkg::IDX_W-1:0]     block_number_o,
  output logic [bba_pkg::CNT_OUT_W-1:0] free_blocks_o
);

  // front -> queue
  logic          fe_vld;
  logic          fe_rdy;
  bba_pkg::cmd_t fe_cmd;

  // queue -> engine
  logic          q_vld;
  logic          q_rd;
  bba_pkg::cmd_t q_cmd;

  // Decode: kind -> alloc flag, index -> word select / bit select
  bba_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .kind_i        (kind_i),
    .block_index_i (block_index_i),
    .cmd_vld_o     (fe_vld),
    .cmd_o         (fe_cmd),
    .cmd_rdy_i     (fe_rdy)
  );

  // Short queue so decode keeps going while the engine scans
  bba_cmd_fifo u_cmd_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_vld_i (fe_vld),
    .wr_rdy_o (fe_rdy),
    .wr_cmd_i (fe_cmd),
    .rd_vld_o (q_vld),
    .rd_en_i  (q_rd),
    .rd_cmd_o (q_cmd)
  );

  // Map engine with its own result register
  bba_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_vld_i      (q_vld),
    .cmd_i          (q_cmd),
    .cmd_rd_o       (q_rd),
    .empty          (empty),
    .pop            (pop),
    .granted_o      (granted_o),
    .block_number_o (block_number_o),
    .free_blocks_o  (free_blocks_o)
  );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit bitmap block allocator.
// Allocate and free requests go in through push/full with random gaps. Each
// accepted request is run through a free-map shadow that works out the
// expected result word. Words popped from the result side are checked field
// by field against the oldest expectation, with random pop stalls and one
// long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import bba_pkg::*;

  // One result word as the block reports it
  typedef struct packed {
    logic                 granted;
    logic [IDX_W-1:0]     number;
    logic [CNT_OUT_W-1:0] free_cnt;
  } alloc_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 push          = 1'b0;
  logic                 full;
  logic                 kind_i        = KIND_ALLOC;
  logic [IDX_W-1:0]     block_index_i = '0;
  logic                 empty;
  logic                 pop           = 1'b0;
  logic                 granted_o;
  logic [IDX_W-1:0]     block_number_o;
  logic [CNT_OUT_W-1:0] free_blocks_o;

  // Shadow of the pool: one bit per block, 1 = free, plus its population
  logic [POOL_BLOCKS-1:0] shadow_free;
  int unsigned            shadow_count;

  alloc_result_t pending_results[$];   // expected words, oldest first
  int unsigned   mismatch_count    = 0;
  int unsigned   sink_hold_cycles  = 0; // one-off hold-off request for the sink
  bit            no_gaps           = 1'b0;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bitmap_block_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .kind_i         (kind_i),
    .block_index_i  (block_index_i),
    .empty          (empty),
    .pop            (pop),
    .granted_o      (granted_o),
    .block_number_o (block_number_o),
    .free_blocks_o  (free_blocks_o)
  );

  task automatic report_mismatch(input string what);
    mismatch_count++;
    // keep the log bounded if the block is badly broken
    if (mismatch_count <= 100) $display("[%0t] %s", $realtime, what);
  endtask

  // Applies one request to the shadow pool and returns the word it should give.
  // Allocate: lowest free block wins; an empty pool gives granted = 0, number 0.
  // Free: echoes the index; freeing a free block leaves the count alone.
  function automatic alloc_result_t predict_step(input logic kind,
                                                 input logic [IDX_W-1:0] idx);
    alloc_result_t r;
    bit            found;
    int            b;
    r     = '0;
    found = 1'b0;
    if (kind == KIND_ALLOC) begin
      for (b = 0; b < POOL_BLOCKS; b++) begin
        if (!found && shadow_free[b]) begin
          found          = 1'b1;
          shadow_free[b] = 1'b0;
          shadow_count--;
          r.granted      = 1'b1;
          r.number       = IDX_W'(b);
        end
      end
    end else begin
      r.number = idx;
      // out-of-range index only exists for pools below 256 blocks
      if (int'(idx) < POOL_BLOCKS) begin
        if (!shadow_free[idx]) begin
          shadow_free[idx] = 1'b1;
          shadow_count++;
        end
        r.granted = 1'b1;
      end
    end
    r.free_cnt = (shadow_count > CNT_SAT) ? CNT_OUT_W'(CNT_SAT) : CNT_OUT_W'(shadow_count);
    return r;
  endfunction

  // Some block currently held, searched from a random start; random if none is
  function automatic logic [IDX_W-1:0] pick_busy_block();
    int unsigned start, k, b;
    start = $urandom_range(0, POOL_BLOCKS - 1);
    for (k = 0; k < POOL_BLOCKS; k++) begin
      b = (start + k) % POOL_BLOCKS;
      if (!shadow_free[b]) return IDX_W'(b);
    end
    return IDX_W'(start);
  endfunction

  // Offers one request word and waits for it to be taken. Push stays high
  // into the next call when no gap is drawn.
  task automatic send_request(input logic kind, input logic [IDX_W-1:0] idx);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push          <= 1'b1;
    kind_i        <= kind;
    block_index_i <= idx;
    do @(posedge clk_i); while (full !== 1'b0);
    pending_results.push_back(predict_step(kind, idx));
  endtask

  // Fresh pool: first fit, refreeing, freeing an already-free block at both
  // ends of the index range, and a full pool restored.
  task automatic test_directed();
    send_request(KIND_ALLOC, '0);                 // block 0
    send_request(KIND_ALLOC, '1);                 // block 1, index ignored
    send_request(KIND_FREE,  '0);                 // hole at 0
    send_request(KIND_FREE,  '0);                 // already free: count unchanged
    send_request(KIND_FREE,  IDX_W'(POOL_BLOCKS - 1)); // top block, already free
    send_request(KIND_ALLOC, IDX_W'(8'hA5));      // hole at 0 refilled
    send_request(KIND_ALLOC, IDX_W'(8'h5A));      // block 2
    send_request(KIND_FREE,  IDX_W'(1));
    send_request(KIND_ALLOC, '1);                 // back to block 1
    send_request(KIND_FREE,  IDX_W'(2));
    send_request(KIND_FREE,  IDX_W'(1));
    send_request(KIND_FREE,  '0);                 // whole pool free again
    send_request(KIND_ALLOC, '0);
    send_request(KIND_FREE,  '0);
  endtask

  // Drains the pool while the sink sits on its hands for a long stretch, so
  // the block backs up and holds full. Then allocates from an empty pool and
  // checks refills land on the lowest freed block across map word boundaries.
  task automatic test_pool_exhaustion();
    int unsigned k;
    sink_hold_cycles = 400;
    while (shadow_count != 0) send_request(KIND_ALLOC, IDX_W'($urandom));
    for (k = 0; k < 4; k++) send_request(KIND_ALLOC, IDX_W'($urandom)); // nothing left
    send_request(KIND_FREE,  IDX_W'(POOL_BLOCKS - 1));
    send_request(KIND_ALLOC, '0);                 // top block comes back
    send_request(KIND_ALLOC, '0);                 // empty again
    send_request(KIND_FREE,  IDX_W'(191));
    send_request(KIND_FREE,  IDX_W'(64));
    send_request(KIND_FREE,  IDX_W'(63));
    send_request(KIND_FREE,  IDX_W'(128));
    send_request(KIND_FREE,  '0);
    for (k = 0; k < 6; k++) send_request(KIND_ALLOC, IDX_W'($urandom)); // 0,63,64,128,191,none
  endtask

  // Phases of differing allocate/free balance so the pool swings between
  // nearly full and nearly empty; most frees hit held blocks, some are random.
  task automatic test_random_mix();
    int unsigned alloc_pct[8] = '{90, 15, 55, 80, 20, 60, 97, 35};
    int unsigned ph, n;
    for (ph = 0; ph < 8; ph++) begin
      no_gaps = (ph % 3 == 2);   // a back-to-back phase every so often
      for (n = 0; n < 135; n++) begin
        if ($urandom_range(1, 100) <= alloc_pct[ph])
          send_request(KIND_ALLOC, IDX_W'($urandom));
        else if ($urandom_range(0, 3) != 0)
          send_request(KIND_FREE, pick_busy_block());
        else
          send_request(KIND_FREE, IDX_W'($urandom));
      end
    end
    no_gaps = 1'b0;
  endtask

  // Result side: random pop gaps, one long hold when asked, field-wise check
  initial begin : result_sink
    alloc_result_t want;
    int unsigned   gap;
    @(posedge rst_ni);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 13);
      if (sink_hold_cycles != 0) begin
        gap              = sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty !== 1'b0);
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word with nothing pending: g=%0b n=%0d f=%0d",
                                  granted_o, block_number_o, free_blocks_o));
      end else begin
        want = pending_results.pop_front();
        if (granted_o !== want.granted)
          report_mismatch($sformatf("granted %0b, want %0b", granted_o, want.granted));
        if (block_number_o !== want.number)
          report_mismatch($sformatf("block_number %0d, want %0d",
                                    block_number_o, want.number));
        if (free_blocks_o !== want.free_cnt)
          report_mismatch($sformatf("free_blocks %0d, want %0d",
                                    free_blocks_o, want.free_cnt));
      end
    end
  end

  initial begin : test_sequence
    int unsigned waited;
    shadow_free  = '1;
    shadow_count = POOL_BLOCKS;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_pool_exhaustion();
    test_random_mix();
    push <= 1'b0;

    // drain, then a short quiet spell to catch stray result words
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", pending_results.size()));
    repeat (32) @(posedge clk_i);

    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog, well past the slowest legal run
  initial begin : watchdog
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
rtl/bba_pkg.sv
rtl/bba_front.sv
rtl/bba_cmd_fifo.sv
rtl/bba_back.sv
rtl/bitmap_block_allocator.sv
dv/tb_top.sv
